// ===== sv/pbgs_pkg.sv =====
`timescale 1ns / 1ps
// Package with the shared types, codes and helper function of the Poisson blend solver.
package pbgs_pkg;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_SOLVE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   localparam logic [2:0] CSR_REGION_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_REGION_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_SWEEP_COUNT   = 3'd2;
   localparam logic [2:0] CSR_SWEEP_ORDER   = 3'd3;
   localparam logic [2:0] CSR_MASK_ENABLE   = 3'd4;

   localparam int ValW   = 20;
   localparam int ImgW   = 3 * ValW;
   localparam int GuideW = 24;
   localparam int AccW   = 23;

   typedef struct packed {
      logic [1:0] opcode;
      logic [5:0] col;
      logic [5:0] row;
      logic [7:0] target_blue;
      logic [7:0] target_green;
      logic [7:0] target_red;
      logic [7:0] guide_blue;
      logic [7:0] guide_green;
      logic [7:0] guide_red;
      logic       mask_bit;
   } req_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_PHASE,
      ST_PIXEL
   } state_type;

   typedef enum logic [2:0] {
      ALU_HOLD,
      ALU_LAP_CENTER,
      ALU_RLX_CENTER,
      ALU_ADD_IMG,
      ALU_ADD_GUIDE
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
   } alu_ctrl_type;

   // Round a 20-bit fixed-point value to the nearest byte, saturated to 0..255.
   function automatic logic [7:0] to_byte(input logic [ValW-1:0] v);
      logic signed [ValW:0]   t;
      logic signed [ValW-8:0] s;
      t = $signed({v[ValW-1], v}) + 21'sd128;
      s = t[ValW:8];
      if (t <= 0) begin
         return 8'd0;
      end else if (s > 255) begin
         return 8'd255;
      end else begin
         return s[7:0];
      end
   endfunction

endpackage

// ===== sv/pbgs_alu.sv =====
`timescale 1ns / 1ps
// Shared three-lane accumulate unit for Laplacian and relaxation updates.
module pbgs_alu (
   input  logic                    clock,
   input  pbgs_pkg::alu_ctrl_type  ctrl,
   input  logic [pbgs_pkg::ImgW-1:0]   img_q,
   input  logic [pbgs_pkg::GuideW-1:0] guide_q,
   input  logic [pbgs_pkg::ImgW-1:0]   lap_q,
   output logic [pbgs_pkg::ImgW-1:0]   relax_word,
   output logic [pbgs_pkg::ImgW-1:0]   lap_word
);

   localparam int VW = pbgs_pkg::ValW;
   localparam int AW = pbgs_pkg::AccW;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      logic signed [AW-1:0] acc_ff;
      logic signed [AW-1:0] acc_in;
      logic signed [AW-1:0] img_ext;
      logic signed [AW-1:0] lap_ext;
      logic signed [AW-1:0] gd_ext;
      logic signed [AW-1:0] quarter;

      assign img_ext = {{(AW-VW){img_q[VW*i+VW-1]}}, img_q[VW*i +: VW]};
      assign lap_ext = {{(AW-VW){lap_q[VW*i+VW-1]}}, lap_q[VW*i +: VW]};
      assign gd_ext  = {{(AW-8){1'b0}}, guide_q[8*i +: 8]};

      always_comb begin
         unique case (ctrl.op)
            pbgs_pkg::ALU_LAP_CENTER: acc_in = -(gd_ext <<< 2);
            pbgs_pkg::ALU_RLX_CENTER: acc_in = -lap_ext;
            pbgs_pkg::ALU_ADD_IMG:    acc_in = acc_ff + img_ext;
            pbgs_pkg::ALU_ADD_GUIDE:  acc_in = acc_ff + gd_ext;
            default:                  acc_in = acc_ff;
         endcase
      end

      always_ff @(posedge clock) begin
         acc_ff <= acc_in;
      end

      // Floor division by four, then saturation to the 20-bit range.
      assign quarter = acc_ff >>> 2;

      always_comb begin
         if (quarter > $signed(AW'(524287))) begin
            relax_word[VW*i +: VW] = 20'h7FFFF;
         end else if (quarter < -$signed(AW'(524288))) begin
            relax_word[VW*i +: VW] = 20'h80000;
         end else begin
            relax_word[VW*i +: VW] = quarter[VW-1:0];
         end
      end

      // The guide Laplacian fits in 12 bits, scaled by 256.
      assign lap_word[VW*i +: VW] = {acc_ff[11:0], 8'h00};
   end

endmodule

// ===== sv/pbgs_store.sv =====
`timescale 1ns / 1ps
// Pixel stores: solution, guide, Laplacian and mask memories with registered reads.
module pbgs_store #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic                        clock,
   input  logic [ADDR_W-1:0]           rd_addr,
   input  logic                        img_we,
   input  logic [ADDR_W-1:0]           img_waddr,
   input  logic [pbgs_pkg::ImgW-1:0]   img_wdata,
   input  logic                        load_we,
   input  logic [ADDR_W-1:0]           load_addr,
   input  logic [pbgs_pkg::GuideW-1:0] guide_wdata,
   input  logic                        mask_wdata,
   input  logic                        lap_we,
   input  logic [ADDR_W-1:0]           lap_waddr,
   input  logic [pbgs_pkg::ImgW-1:0]   lap_wdata,
   output logic [pbgs_pkg::ImgW-1:0]   img_q,
   output logic [pbgs_pkg::GuideW-1:0] guide_q,
   output logic [pbgs_pkg::ImgW-1:0]   lap_q,
   output logic                        mask_q
);

   logic [pbgs_pkg::ImgW-1:0]   img_mem   [DEPTH];
   logic [pbgs_pkg::GuideW-1:0] guide_mem [DEPTH];
   logic [pbgs_pkg::ImgW-1:0]   lap_mem   [DEPTH];
   logic                        mask_mem  [DEPTH];

   always_ff @(posedge clock) begin
      if (img_we) begin
         img_mem[img_waddr] <= img_wdata;
      end
      img_q <= img_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         guide_mem[load_addr] <= guide_wdata;
         mask_mem[load_addr]  <= mask_wdata;
      end
      guide_q <= guide_mem[rd_addr];
      mask_q  <= mask_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (lap_we) begin
         lap_mem[lap_waddr] <= lap_wdata;
      end
      lap_q <= lap_mem[rd_addr];
   end

endmodule

// ===== sv/poisson_blend_gauss_seidel_solver.sv =====
`timescale 1ns / 1ps
// Top level of the Poisson blend Gauss-Seidel solver: sequencer, registers and ports.
//
// Requests carry an opcode. A load request writes one target pixel, one guide pixel and
// one mask bit; loads stream at one per cycle while no response waits to be taken. A
// read request yields one registered response with the solved pixel rounded to bytes; a
// read outside the store returns zeros. A solve request first forms the guide Laplacian
// at every interior pixel and then runs sweep_count Gauss-Seidel sweeps in place, in
// raster or four-phase odd/even order, holding border pixels fixed; with mask_enable set,
// both passes skip pixels whose mask bit is clear. All work goes through one three-lane
// accumulate unit fed by one read port per store, so each pixel visit reads the center
// and its four neighbours in turn (five reads), finishes the sum and writes back. The
// region size is limited to MAX_COLS and MAX_ROWS. No request is taken while a solve or
// read is running. The stores are not cleared at reset; pixels must be loaded before
// they are solved or read.
module poisson_blend_gauss_seidel_solver #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pbgs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pbgs_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   localparam int DEPTH  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);

   // Configuration registers.
   logic [6:0]  region_width_ff;
   logic [6:0]  region_height_ff;
   logic [15:0] sweep_count_ff;
   logic        sweep_order_ff;
   logic        mask_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_width_ff  <= 7'd64;
         region_height_ff <= 7'd64;
         sweep_count_ff   <= 16'd100;
         sweep_order_ff   <= 1'b0;
         mask_enable_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            pbgs_pkg::CSR_REGION_WIDTH:  region_width_ff  <= csr_wdata[6:0];
            pbgs_pkg::CSR_REGION_HEIGHT: region_height_ff <= csr_wdata[6:0];
            pbgs_pkg::CSR_SWEEP_COUNT:   sweep_count_ff   <= csr_wdata;
            pbgs_pkg::CSR_SWEEP_ORDER:   sweep_order_ff   <= csr_wdata[0];
            pbgs_pkg::CSR_MASK_ENABLE:   mask_enable_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective region size, limited to the store dimensions.
   logic [6:0] w_eff;
   logic [6:0] h_eff;
   assign w_eff = (int'(region_width_ff) > MAX_COLS) ? 7'(MAX_COLS) : region_width_ff;
   assign h_eff = (int'(region_height_ff) > MAX_ROWS) ? 7'(MAX_ROWS) : region_height_ff;

   // Sequencer state.
   pbgs_pkg::state_type state_ff, state_in;
   logic        lap_pass_ff, lap_pass_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] sweep_left_ff, sweep_left_in;
   logic [7:0]  r_ff, r_in;
   logic [7:0]  c_ff, c_in;
   logic [2:0]  tick_ff, tick_in;
   logic        inside_ff, inside_in;
   logic        skip_ff, skip_in;
   logic        phase_done;
   logic        rsp_valid_ff, rsp_valid_in;
   pbgs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic req_fire;
   logic req_inside;
   logic [ADDR_W-1:0] req_addr;
   logic [ADDR_W-1:0] center;
   logic [ADDR_W-1:0] rd_addr_in;

   // Phase geometry: start row and column and stride of the current pass.
   logic [7:0] step;
   logic [7:0] r0;
   logic [7:0] c0;
   logic [8:0] c_next;
   logic [8:0] r_next;

   assign step = (!lap_pass_ff && sweep_order_ff) ? 8'd2 : 8'd1;
   assign r0   = (!lap_pass_ff && sweep_order_ff) ? 8'd1 + {7'd0, phase_ff[1]} : 8'd1;
   assign c0   = (!lap_pass_ff && sweep_order_ff) ? 8'd1 + {7'd0, phase_ff[0]} : 8'd1;
   assign c_next = {1'b0, c_ff} + {1'b0, step};
   assign r_next = {1'b0, r_ff} + {1'b0, step};

   assign req_fire   = req_valid && req_ready;
   assign req_inside = (int'(req_data.col) < MAX_COLS) && (int'(req_data.row) < MAX_ROWS);
   assign req_addr   = ADDR_W'(ADDR_W'(req_data.row) * ADDR_W'(MAX_COLS)
                               + ADDR_W'(req_data.col));
   assign center     = ADDR_W'(ADDR_W'(r_ff) * ADDR_W'(MAX_COLS) + ADDR_W'(c_ff));

   // Store and arithmetic unit hookup.
   logic [pbgs_pkg::ImgW-1:0]   img_q;
   logic [pbgs_pkg::GuideW-1:0] guide_q;
   logic [pbgs_pkg::ImgW-1:0]   lap_q;
   logic                        mask_q;
   logic [pbgs_pkg::ImgW-1:0]   relax_word;
   logic [pbgs_pkg::ImgW-1:0]   lap_word;
   logic                        load_we;
   logic                        relax_we;
   logic                        lap_we;
   logic                        img_we;
   logic [ADDR_W-1:0]           img_waddr;
   logic [pbgs_pkg::ImgW-1:0]   img_wdata;
   logic [pbgs_pkg::ImgW-1:0]   load_word;
   pbgs_pkg::alu_ctrl_type      alu_ctrl;

   // Next state and counters.
   always_comb begin
      state_in      = state_ff;
      lap_pass_in   = lap_pass_ff;
      phase_in      = phase_ff;
      sweep_left_in = sweep_left_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      tick_in       = tick_ff;
      inside_in     = inside_ff;
      skip_in       = skip_ff;
      phase_done    = 1'b0;

      unique case (state_ff)
         pbgs_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_data.opcode == pbgs_pkg::OP_SOLVE) begin
                  if (w_eff >= 7'd3 && h_eff >= 7'd3) begin
                     lap_pass_in = 1'b1;
                     phase_in    = 2'd0;
                     state_in    = pbgs_pkg::ST_PHASE;
                  end
               end else if (req_data.opcode == pbgs_pkg::OP_READ) begin
                  inside_in = req_inside;
                  state_in  = pbgs_pkg::ST_READ;
               end
            end
         end
         pbgs_pkg::ST_READ: begin
            state_in = pbgs_pkg::ST_IDLE;
         end
         pbgs_pkg::ST_PHASE: begin
            if ({1'b0, r0} + 9'd1 < {2'b0, h_eff} && {1'b0, c0} + 9'd1 < {2'b0, w_eff}) begin
               r_in     = r0;
               c_in     = c0;
               tick_in  = 3'd0;
               state_in = pbgs_pkg::ST_PIXEL;
            end else begin
               phase_done = 1'b1;
            end
         end
         pbgs_pkg::ST_PIXEL: begin
            if (tick_ff == 3'd1) begin
               skip_in = mask_enable_ff && !mask_q;
            end
            if (tick_ff != 3'd6) begin
               tick_in = tick_ff + 3'd1;
            end else begin
               tick_in = 3'd0;
               if (c_next + 9'd1 < {2'b0, w_eff}) begin
                  c_in = c_next[7:0];
               end else if (r_next + 9'd1 < {2'b0, h_eff}) begin
                  r_in = r_next[7:0];
                  c_in = c0;
               end else begin
                  phase_done = 1'b1;
               end
            end
         end
         default: state_in = pbgs_pkg::ST_IDLE;
      endcase

      // End of a phase: move to the next phase, the next sweep, or finish.
      if (phase_done) begin
         phase_in = 2'd0;
         state_in = pbgs_pkg::ST_PHASE;
         if (lap_pass_ff) begin
            lap_pass_in   = 1'b0;
            sweep_left_in = sweep_count_ff;
            if (sweep_count_ff == 16'd0) begin
               state_in = pbgs_pkg::ST_IDLE;
            end
         end else if (sweep_order_ff && phase_ff != 2'd3) begin
            phase_in = phase_ff + 2'd1;
         end else begin
            sweep_left_in = sweep_left_ff - 16'd1;
            if (sweep_left_ff == 16'd1) begin
               state_in = pbgs_pkg::ST_IDLE;
            end
         end
      end
   end

   // Outputs of the sequencer: handshake, read address, unit control, writes.
   always_comb begin
      req_ready   = 1'b0;
      rd_addr_in  = center;
      alu_ctrl.op = pbgs_pkg::ALU_HOLD;
      relax_we    = 1'b0;
      lap_we      = 1'b0;

      unique case (state_ff)
         pbgs_pkg::ST_IDLE: begin
            req_ready  = !rsp_valid_ff || rsp_ready;
            rd_addr_in = req_addr;
         end
         pbgs_pkg::ST_PIXEL: begin
            // Reads: center, up, down, left, right; data arrives in the next cycle.
            unique case (tick_ff)
               3'd1:    rd_addr_in = ADDR_W'(center - ADDR_W'(MAX_COLS));
               3'd2:    rd_addr_in = ADDR_W'(center + ADDR_W'(MAX_COLS));
               3'd3:    rd_addr_in = ADDR_W'(center - ADDR_W'(1));
               3'd4:    rd_addr_in = ADDR_W'(center + ADDR_W'(1));
               default: rd_addr_in = center;
            endcase
            if (tick_ff == 3'd1) begin
               alu_ctrl.op = lap_pass_ff ? pbgs_pkg::ALU_LAP_CENTER : pbgs_pkg::ALU_RLX_CENTER;
            end else if (tick_ff >= 3'd2 && tick_ff <= 3'd5) begin
               alu_ctrl.op = lap_pass_ff ? pbgs_pkg::ALU_ADD_GUIDE : pbgs_pkg::ALU_ADD_IMG;
            end
            if (tick_ff == 3'd6 && !skip_ff) begin
               lap_we   = lap_pass_ff;
               relax_we = !lap_pass_ff;
            end
         end
         default: ;
      endcase
   end

   assign load_we   = req_fire && req_data.opcode == pbgs_pkg::OP_LOAD && req_inside;
   assign load_word = {4'd0, req_data.target_red,   8'd0,
                       4'd0, req_data.target_green, 8'd0,
                       4'd0, req_data.target_blue,  8'd0};
   assign img_we    = load_we || relax_we;
   assign img_waddr = load_we ? req_addr : center;
   assign img_wdata = load_we ? load_word : relax_word;

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == pbgs_pkg::ST_READ) begin
         rsp_valid_in = 1'b1;
         if (inside_ff) begin
            rsp_data_in.out_blue  = pbgs_pkg::to_byte(img_q[19:0]);
            rsp_data_in.out_green = pbgs_pkg::to_byte(img_q[39:20]);
            rsp_data_in.out_red   = pbgs_pkg::to_byte(img_q[59:40]);
         end else begin
            rsp_data_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbgs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lap_pass_ff   <= lap_pass_in;
      phase_ff      <= phase_in;
      sweep_left_ff <= sweep_left_in;
      r_ff          <= r_in;
      c_ff          <= c_in;
      tick_ff       <= tick_in;
      inside_ff     <= inside_in;
      skip_ff       <= skip_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   pbgs_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock       (clock),
      .rd_addr     (rd_addr_in),
      .img_we      (img_we),
      .img_waddr   (img_waddr),
      .img_wdata   (img_wdata),
      .load_we     (load_we),
      .load_addr   (req_addr),
      .guide_wdata ({req_data.guide_red, req_data.guide_green, req_data.guide_blue}),
      .mask_wdata  (req_data.mask_bit),
      .lap_we      (lap_we),
      .lap_waddr   (center),
      .lap_wdata   (lap_word),
      .img_q       (img_q),
      .guide_q     (guide_q),
      .lap_q       (lap_q),
      .mask_q      (mask_q)
   );

   pbgs_alu u_alu (
      .clock      (clock),
      .ctrl       (alu_ctrl),
      .img_q      (img_q),
      .guide_q    (guide_q),
      .lap_q      (lap_q),
      .relax_word (relax_word),
      .lap_word   (lap_word)
   );

endmodule
